// ----- rtl/ssat_pkg.sv -----
// shared constants, widths, index tables and command/status structs
// for the simplex separating axis test; used by every rtl file
package ssat_pkg;

  localparam int COORD_BITS = 8;                    // stored bits per coordinate
  localparam int IN_W       = 8;                    // port width of a coordinate
  localparam int VW         = COORD_BITS + 1;       // vertex difference
  localparam int AW         = 2 * COORD_BITS + 3;   // axis component
  localparam int PW         = AW + VW;              // one projection product
  localparam int DW         = PW + 2;               // dot product
  localparam int VTX_W      = 3 * COORD_BITS;       // one stored vertex

  // edge end points, first end then second end
  localparam logic [1:0] EDGE_END [6][2] = '{
    '{2'd1, 2'd0}, '{2'd2, 2'd0}, '{2'd2, 2'd1},
    '{2'd3, 2'd0}, '{2'd3, 2'd1}, '{2'd3, 2'd2}
  };

  // facet corner points
  localparam logic [1:0] FACET_PT [4][3] = '{
    '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd3}
  };

  typedef struct packed {
    logic       wr_en;
    logic [2:0] wr_addr;
    logic [2:0] rd_addr0;
    logic [2:0] rd_addr1;
    logic       lat_a;
    logic       lat_b;
    logic       x1;
    logic       x2;
    logic       proj_issue;
    logic       share_issue;
    logic       share_clr;
    logic       tri_mode;
  } cmd_t;

  typedef struct packed {
    logic axis_zero;
    logic sep;
  } sts_t;

endpackage

// ----- rtl/ssat_dp.sv -----
// datapath: vertex memory, edge vectors, three shared multipliers,
// projection pipeline and range decision; depends on ssat_pkg
module ssat_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssat_pkg::cmd_t          cmd_i,
  input  logic [ssat_pkg::IN_W-1:0] coord_x_i,
  input  logic [ssat_pkg::IN_W-1:0] coord_y_i,
  input  logic [ssat_pkg::IN_W-1:0] coord_z_i,
  output ssat_pkg::sts_t          sts_o
);
  import ssat_pkg::*;

  logic [VTX_W-1:0] mem [8];
  logic [VTX_W-1:0] rd0_q, rd1_q;

  logic signed [VW-1:0] va_q [3];
  logic signed [VW-1:0] vb_q [3];
  logic signed [AW-1:0] axis_q [3];
  logic signed [PW-1:0] t_q [3];
  logic signed [PW-1:0] prod_q [3];
  logic signed [AW-1:0] opa [3];
  logic signed [VW-1:0] opb [3];
  logic signed [PW-1:0] prod [3];
  logic signed [DW-1:0] dot_q;
  logic signed [DW-1:0] dots_q [8];
  logic signed [DW-1:0] lo1_q, hi1_q, lo2_q, hi2_q, plane;

  logic       pv1_q, pv2_q, pv3_q, sv1_q;
  logic [2:0] pidx1_q, pidx2_q, pidx0_q;
  logic [3:0] sidx0_q;
  logic [3:0] match_q;
  logic       p_used;
  logic [2:0] n1, n2, least, shared;

  function automatic logic signed [VW-1:0] coord(input logic [VTX_W-1:0] v, input int k);
    return $signed({1'b0, v[k*COORD_BITS +: COORD_BITS]});
  endfunction

  // memory write and registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= {coord_z_i[COORD_BITS-1:0], coord_y_i[COORD_BITS-1:0],
                             coord_x_i[COORD_BITS-1:0]};
    end
    rd0_q <= mem[cmd_i.rd_addr0];
    rd1_q <= mem[cmd_i.rd_addr1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv1_q <= 1'b0;
      pv2_q <= 1'b0;
      pv3_q <= 1'b0;
      sv1_q <= 1'b0;
    end else begin
      pv1_q <= cmd_i.proj_issue;
      pv2_q <= pv1_q;
      pv3_q <= pv2_q;
      sv1_q <= cmd_i.share_issue;
    end
  end

  // operand select for the shared multipliers
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (pv1_q) begin
        opa[k] = axis_q[k];
        opb[k] = coord(rd0_q, k);
      end else if (cmd_i.x2) begin
        opa[k] = AW'(va_q[(k + 2) % 3]);
        opb[k] = vb_q[(k + 1) % 3];
      end else begin
        opa[k] = AW'(va_q[(k + 1) % 3]);
        opb[k] = vb_q[(k + 2) % 3];
      end
      prod[k] = opa[k] * opb[k];
    end
  end

  always_ff @(posedge clk_i) begin
    pidx0_q <= cmd_i.rd_addr0;
    pidx1_q <= pidx0_q;
    pidx2_q <= pidx1_q;
    sidx0_q <= {cmd_i.rd_addr0[1:0], cmd_i.rd_addr1[1:0]};
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.lat_a) va_q[k] <= coord(rd0_q, k) - coord(rd1_q, k);
      if (cmd_i.lat_b) vb_q[k] <= coord(rd0_q, k) - coord(rd1_q, k);
      if (cmd_i.x1) t_q[k] <= prod[k];
      if (cmd_i.x2) axis_q[k] <= AW'(t_q[k] - prod[k]);
      if (pv1_q) prod_q[k] <= prod[k];
    end
    if (pv2_q) dot_q <= DW'(prod_q[0]) + DW'(prod_q[1]) + DW'(prod_q[2]);
    if (pv3_q) begin
      dots_q[pidx2_q] <= dot_q;
      if (!pidx2_q[2]) begin
        if (p_used) begin
          if (pidx2_q[1:0] == 2'd0 || dot_q < lo1_q) lo1_q <= dot_q;
          if (pidx2_q[1:0] == 2'd0 || dot_q > hi1_q) hi1_q <= dot_q;
        end
      end else begin
        if (pidx2_q[1:0] == 2'd0 || dot_q < lo2_q) lo2_q <= dot_q;
        if (pidx2_q[1:0] == 2'd0 || dot_q > hi2_q) hi2_q <= dot_q;
      end
    end
    if (cmd_i.share_clr) begin
      match_q <= '0;
    end else if (sv1_q && rd0_q == rd1_q) begin
      match_q[sidx0_q[3:2]] <= 1'b1;
    end
  end

  assign p_used = !(cmd_i.tri_mode && pidx2_q[1:0] == 2'd3);

  // range decision
  always_comb begin
    plane  = (hi1_q == lo2_q) ? hi1_q : hi2_q;
    n1     = '0;
    n2     = '0;
    shared = '0;
    for (int i = 0; i < 4; i++) begin
      if (!(cmd_i.tri_mode && i == 3)) begin
        if (dots_q[i] == plane) n1 = n1 + 3'd1;
        if (match_q[i]) shared = shared + 3'd1;
      end
      if (dots_q[i + 4] == plane) n2 = n2 + 3'd1;
    end
    least = (n1 < n2) ? n1 : n2;
    sts_o.axis_zero = (axis_q[0] == '0) && (axis_q[1] == '0) && (axis_q[2] == '0);
    if (hi1_q < lo2_q || hi2_q < lo1_q) begin
      sts_o.sep = 1'b1;
    end else if (hi1_q > lo2_q && hi2_q > lo1_q) begin
      sts_o.sep = 1'b0;
    end else begin
      sts_o.sep = (least == shared);
    end
  end

endmodule

// ----- rtl/ssat_ctrl.sv -----
// controller: handshakes, axis sequencing, memory addressing and result
// register; drives the datapath through cmd_t, depends on ssat_pkg
module ssat_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     slot_i,
  input  logic           first_is_triangle_i,
  input  logic           go_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           disjoint_o,
  output ssat_pkg::cmd_t cmd_o,
  input  ssat_pkg::sts_t sts_i
);
  import ssat_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SHARE   = 4'd1;
  localparam logic [3:0] S_SHARE_D = 4'd2;
  localparam logic [3:0] S_AX_A    = 4'd3;
  localparam logic [3:0] S_AX_B    = 4'd4;
  localparam logic [3:0] S_AX_L    = 4'd5;
  localparam logic [3:0] S_X1      = 4'd6;
  localparam logic [3:0] S_X2      = 4'd7;
  localparam logic [3:0] S_CHK     = 4'd8;
  localparam logic [3:0] S_FB_A    = 4'd9;
  localparam logic [3:0] S_FB_L    = 4'd10;
  localparam logic [3:0] S_PROJ    = 4'd11;
  localparam logic [3:0] S_DRAIN   = 4'd12;
  localparam logic [3:0] S_DECIDE  = 4'd13;

  localparam logic [1:0] PH_FP   = 2'd0;
  localparam logic [1:0] PH_FQ   = 2'd1;
  localparam logic [1:0] PH_EDGE = 2'd2;

  logic [3:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] phase_q, phase_d;
  logic [1:0] fi_q, fi_d;
  logic [2:0] ei_q, ei_d, ej_q, ej_d;
  logic       fb_q, fb_d, tri_q, tri_d;
  logic       out_valid_q, out_valid_d, disjoint_q, disjoint_d;
  logic       in_acc, last_axis;
  logic [1:0] nx_phase, nx_fi;
  logic [2:0] nx_ei, nx_ej;
  logic [2:0] base;

  assign in_ready_o  = (state_q == S_IDLE) && !(go_i && out_valid_q);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign disjoint_o  = disjoint_q;

  // next axis in the sequence
  always_comb begin
    nx_phase  = phase_q;
    nx_fi     = fi_q;
    nx_ei     = ei_q;
    nx_ej     = ej_q;
    last_axis = 1'b0;
    unique case (phase_q)
      PH_FP: begin
        if (tri_q || fi_q == 2'd3) begin
          nx_phase = PH_FQ;
          nx_fi    = 2'd0;
        end else begin
          nx_fi = fi_q + 2'd1;
        end
      end
      PH_FQ: begin
        if (fi_q == 2'd3) begin
          nx_phase = PH_EDGE;
          nx_ei    = 3'd0;
          nx_ej    = 3'd0;
        end else begin
          nx_fi = fi_q + 2'd1;
        end
      end
      default: begin
        if (ej_q == 3'd5) begin
          nx_ej = 3'd0;
          nx_ei = ei_q + 3'd1;
          last_axis = (ei_q == (tri_q ? 3'd2 : 3'd5));
        end else begin
          nx_ej = ej_q + 3'd1;
        end
      end
    endcase
  end

  assign base = (phase_q == PH_FQ) ? 3'd4 : 3'd0;

  // memory read addresses and datapath commands by state
  always_comb begin
    cmd_o             = '0;
    cmd_o.tri_mode    = tri_q;
    cmd_o.wr_en       = in_acc && !go_i;
    cmd_o.wr_addr     = slot_i;
    cmd_o.share_clr   = in_acc && go_i;
    cmd_o.lat_a       = (state_q == S_AX_B);
    cmd_o.lat_b       = (state_q == S_AX_L) || (state_q == S_FB_L);
    cmd_o.x1          = (state_q == S_X1);
    cmd_o.x2          = (state_q == S_X2);
    cmd_o.proj_issue  = (state_q == S_PROJ);
    cmd_o.share_issue = (state_q == S_SHARE);
    priority case (state_q)
      S_SHARE: begin
        cmd_o.rd_addr0 = {1'b0, cnt_q[3:2]};
        cmd_o.rd_addr1 = {1'b1, cnt_q[1:0]};
      end
      S_PROJ: begin
        cmd_o.rd_addr0 = cnt_q[2:0];
      end
      S_FB_A: begin
        cmd_o.rd_addr0 = {1'b0, EDGE_END[ei_q][0]};
        cmd_o.rd_addr1 = {1'b1, EDGE_END[ej_q][0]};
      end
      S_AX_A: begin
        if (phase_q == PH_EDGE) begin
          cmd_o.rd_addr0 = {1'b0, EDGE_END[ei_q][0]};
          cmd_o.rd_addr1 = {1'b0, EDGE_END[ei_q][1]};
        end else begin
          cmd_o.rd_addr0 = base | {1'b0, FACET_PT[fi_q][1]};
          cmd_o.rd_addr1 = base | {1'b0, FACET_PT[fi_q][0]};
        end
      end
      default: begin
        if (phase_q == PH_EDGE) begin
          cmd_o.rd_addr0 = {1'b1, EDGE_END[ej_q][0]};
          cmd_o.rd_addr1 = {1'b1, EDGE_END[ej_q][1]};
        end else begin
          cmd_o.rd_addr0 = base | {1'b0, FACET_PT[fi_q][2]};
          cmd_o.rd_addr1 = base | {1'b0, FACET_PT[fi_q][0]};
        end
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    fi_d        = fi_q;
    ei_d        = ei_q;
    ej_d        = ej_q;
    fb_d        = fb_q;
    tri_d       = tri_q;
    out_valid_d = out_valid_q && !out_ready_i;
    disjoint_d  = disjoint_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && go_i) begin
          state_d = S_SHARE;
          tri_d   = first_is_triangle_i;
          cnt_d   = '0;
          phase_d = PH_FP;
          fi_d    = '0;
          ei_d    = '0;
          ej_d    = '0;
          fb_d    = 1'b0;
        end
      end
      S_SHARE: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) state_d = S_SHARE_D;
      end
      S_SHARE_D: state_d = S_AX_A;
      S_AX_A:    state_d = S_AX_B;
      S_AX_B:    state_d = S_AX_L;
      S_AX_L:    state_d = S_X1;
      S_X1:      state_d = S_X2;
      S_X2:      state_d = S_CHK;
      S_FB_A:    state_d = S_FB_L;
      S_FB_L:    state_d = S_X1;
      S_CHK: begin
        cnt_d = '0;
        if (sts_i.axis_zero && phase_q == PH_EDGE && !fb_q) begin
          state_d = S_FB_A;
          fb_d    = 1'b1;
        end else if (sts_i.axis_zero && phase_q == PH_EDGE) begin
          fb_d = 1'b0;
          if (last_axis) begin
            state_d     = S_IDLE;
            out_valid_d = 1'b1;
            disjoint_d  = 1'b0;
          end else begin
            state_d = S_AX_A;
            phase_d = nx_phase;
            fi_d    = nx_fi;
            ei_d    = nx_ei;
            ej_d    = nx_ej;
          end
        end else begin
          state_d = S_PROJ;
        end
      end
      S_PROJ: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd7) begin
          state_d = S_DRAIN;
          cnt_d   = '0;
        end
      end
      S_DRAIN: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd2) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        fb_d = 1'b0;
        if (sts_i.sep || last_axis) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          disjoint_d  = sts_i.sep;
        end else begin
          state_d = S_AX_A;
          phase_d = nx_phase;
          fi_d    = nx_fi;
          ei_d    = nx_ei;
          ej_d    = nx_ej;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      phase_q     <= PH_FP;
      fi_q        <= '0;
      ei_q        <= '0;
      ej_q        <= '0;
      fb_q        <= 1'b0;
      tri_q       <= 1'b0;
      out_valid_q <= 1'b0;
      disjoint_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      fi_q        <= fi_d;
      ei_q        <= ei_d;
      ej_q        <= ej_d;
      fb_q        <= fb_d;
      tri_q       <= tri_d;
      out_valid_q <= out_valid_d;
      disjoint_q  <= disjoint_d;
    end
  end

  a_go_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && go_i) |=> (state_q == S_SHARE))
    else $error("go transfer did not start the test");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DECIDE || $past(state_q) == S_CHK))
    else $error("result raised outside a decision step");

  a_proj_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROJ) |-> (cnt_q < 4'd8))
    else $error("projection count out of range");

  a_fb_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fb_q |-> (phase_q == PH_EDGE))
    else $error("fallback axis outside edge pairs");

endmodule

// ----- rtl/simplex_separating_axis_test_top.sv -----
// top level of the simplex separating axis test
// joins ssat_ctrl and ssat_dp; depends on ssat_pkg
//
// usage: load vertices with go=0 (slot 0-3 first simplex, 4-7 second
// tetrahedron), then send go=1 to get one disjoint bit. a load transfer
// is accepted whenever the block is idle, also while a result waits. a
// go transfer is held off while the previous result is still waiting. a
// test runs a shared-vertex scan, then for each axis tried memory reads,
// a cross product on three shared multipliers, an eight-vertex projection
// pipeline and a decision; a parallel edge pair tries a fallback axis,
// and a pair whose fallback axis is also zero is skipped. it stops at the
// first separating axis, after at most 44 axes. vertices that were never
// loaded give an unspecified answer
module simplex_separating_axis_test_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                slot_i,
  input  logic [ssat_pkg::IN_W-1:0] coord_x_i,
  input  logic [ssat_pkg::IN_W-1:0] coord_y_i,
  input  logic [ssat_pkg::IN_W-1:0] coord_z_i,
  input  logic                      first_is_triangle_i,
  input  logic                      go_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      disjoint_o
);
  import ssat_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencing, handshakes and result register
  ssat_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .slot_i              (slot_i),
    .first_is_triangle_i (first_is_triangle_i),
    .go_i                (go_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .disjoint_o          (disjoint_o),
    .cmd_o               (cmd),
    .sts_i               (sts)
  );

  // vertex memory and arithmetic
  ssat_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .coord_z_i (coord_z_i),
    .sts_o     (sts)
  );

endmodule

// ----- bench/simplex_separating_axis_test_top_test.sv -----
// testbench for the simplex separating axis test top level
// predicts each disjoint bit from stored vertices; depends on ssat_pkg and the rtl
`timescale 1ns / 100ps

module simplex_separating_axis_test_top_test;
  import ssat_pkg::*;

  typedef struct {
    longint c[3];
  } pt_t;

  // edge and facet index tables of a simplex
  localparam int EA [6] = '{1, 2, 2, 3, 3, 3};
  localparam int EB [6] = '{0, 0, 1, 0, 1, 2};
  localparam int F0 [4] = '{0, 1, 0, 0};
  localparam int F1 [4] = '{1, 2, 2, 1};
  localparam int F2 [4] = '{2, 3, 3, 3};

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [2:0]       slot_i;
  logic [IN_W-1:0]  coord_x_i;
  logic [IN_W-1:0]  coord_y_i;
  logic [IN_W-1:0]  coord_z_i;
  logic             first_is_triangle_i;
  logic             go_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             disjoint_o;

  // local copy of the vertex store
  pt_t    shadow_vtx [8];
  bit     disjoint_q [$];
  int     fail_count;
  longint cycle_count;
  int     stall_mode;

  simplex_separating_axis_test_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .slot_i, .coord_x_i, .coord_y_i,
    .coord_z_i, .first_is_triangle_i, .go_i, .out_valid_o, .out_ready_i, .disjoint_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit: allows for every test, with stalls and gaps, several times over
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 3000000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic pt_t vsub(pt_t a, pt_t b);
    pt_t r;
    for (int k = 0; k < 3; k++) r.c[k] = a.c[k] - b.c[k];
    return r;
  endfunction

  function automatic pt_t vcross(pt_t a, pt_t b);
    pt_t r;
    r.c[0] = a.c[1] * b.c[2] - a.c[2] * b.c[1];
    r.c[1] = a.c[2] * b.c[0] - a.c[0] * b.c[2];
    r.c[2] = a.c[0] * b.c[1] - a.c[1] * b.c[0];
    return r;
  endfunction

  function automatic longint vdot(pt_t a, pt_t b);
    return a.c[0] * b.c[0] + a.c[1] * b.c[1] + a.c[2] * b.c[2];
  endfunction

  function automatic bit vnull(pt_t a);
    return a.c[0] == 0 && a.c[1] == 0 && a.c[2] == 0;
  endfunction

  function automatic bit vsame(pt_t a, pt_t b);
    return a.c[0] == b.c[0] && a.c[1] == b.c[1] && a.c[2] == b.c[2];
  endfunction

  // projection ranges apart, or touching with a proper shared face
  function automatic bit axis_splits(int np, pt_t ax);
    longint lo1, hi1, lo2, hi2, d, plane;
    int n1, n2, shared, least;
    n1 = 0; n2 = 0; shared = 0;
    for (int i = 0; i < np; i++) begin
      d = vdot(ax, shadow_vtx[i]);
      if (i == 0 || d < lo1) lo1 = d;
      if (i == 0 || d > hi1) hi1 = d;
    end
    for (int i = 0; i < 4; i++) begin
      d = vdot(ax, shadow_vtx[4+i]);
      if (i == 0 || d < lo2) lo2 = d;
      if (i == 0 || d > hi2) hi2 = d;
    end
    if (hi1 < lo2 || hi2 < lo1) return 1'b1;
    if (hi1 > lo2 && hi2 > lo1) return 1'b0;
    plane = (hi1 == lo2) ? hi1 : hi2;
    for (int i = 0; i < np; i++) if (vdot(ax, shadow_vtx[i]) == plane) n1++;
    for (int i = 0; i < 4; i++) if (vdot(ax, shadow_vtx[4+i]) == plane) n2++;
    least = (n1 < n2) ? n1 : n2;
    for (int i = 0; i < np; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (vsame(shadow_vtx[i], shadow_vtx[4+j])) begin
          shared++;
          break;
        end
      end
    end
    return least == shared;
  endfunction

  function automatic bit predict_disjoint(bit tri_mode);
    int np, nfa, ne, o;
    pt_t n, ea, eb, ax;
    np = tri_mode ? 3 : 4;
    nfa = tri_mode ? 1 : 4;
    ne = tri_mode ? 3 : 6;
    // facet normals of the first simplex, then of the second
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < (s ? 4 : nfa); i++) begin
        o = 4 * s;
        n = vcross(vsub(shadow_vtx[o+F1[i]], shadow_vtx[o+F0[i]]),
                   vsub(shadow_vtx[o+F2[i]], shadow_vtx[o+F0[i]]));
        if (axis_splits(np, n)) return 1'b1;
      end
    end
    // edge pair cross products, parallel pairs use the fallback axis
    for (int i = 0; i < ne; i++) begin
      ea = vsub(shadow_vtx[EA[i]], shadow_vtx[EB[i]]);
      for (int j = 0; j < 6; j++) begin
        eb = vsub(shadow_vtx[4+EA[j]], shadow_vtx[4+EB[j]]);
        ax = vcross(ea, eb);
        if (vnull(ax)) begin
          ax = vcross(ea, vsub(shadow_vtx[EA[i]], shadow_vtx[4+EA[j]]));
          if (vnull(ax)) continue;
        end
        if (axis_splits(np, ax)) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  // one transfer; the payload is held until accepted
  task automatic send_item(bit go, bit tri_mode, bit [2:0] slot,
                           bit [7:0] x, bit [7:0] y, bit [7:0] z);
    in_valid_i          <= 1'b1;
    go_i                <= go;
    first_is_triangle_i <= tri_mode;
    slot_i              <= slot;
    coord_x_i           <= x;
    coord_y_i           <= y;
    coord_z_i           <= z;
    do @(posedge clk_i); while (!in_ready_o);
    if (go) begin
      disjoint_q.push_back(predict_disjoint(tri_mode));
    end else begin
      shadow_vtx[slot].c[0] = x;
      shadow_vtx[slot].c[1] = y;
      shadow_vtx[slot].c[2] = z;
    end
  endtask

  // bursty sender: random gap only between items, valid never dropped mid-item
  task automatic paced_send(bit go, bit tri_mode, bit [2:0] slot,
                            bit [7:0] x, bit [7:0] y, bit [7:0] z);
    send_item(go, tri_mode, slot, x, y, z);
    if ($urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic load_vtx(int s, int x, int y, int z);
    paced_send(1'b0, 1'(0), 3'(s), 8'(x), 8'(y), 8'(z));
  endtask

  task automatic run_go(bit tri_mode);
    paced_send(1'b1, tri_mode, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // result checker against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (disjoint_q.size() == 0) begin
        report_mismatch("unexpected result", disjoint_o, -1);
      end else begin
        bit want;
        want = disjoint_q.pop_front();
        if (disjoint_o !== want) report_mismatch("disjoint", disjoint_o, want);
      end
    end
  end

  // receiver stall pattern, mode changes now and then
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 3) != 0);
        2:       out_ready_i <= ($urandom_range(0, 1) != 0);
        default: out_ready_i <= (cycle_count[2:0] == 3'd0);
      endcase
    end
  end

  // two well separated unit tetrahedra as a start
  task automatic test_directed;
    load_vtx(0, 0, 0, 0);     load_vtx(1, 1, 0, 0);
    load_vtx(2, 0, 1, 0);     load_vtx(3, 0, 0, 1);
    load_vtx(4, 255, 255, 255); load_vtx(5, 254, 255, 255);
    load_vtx(6, 255, 254, 255); load_vtx(7, 255, 255, 254);
    run_go(1'b0);
    run_go(1'b1);
    // second copy sharing a face: properly face sharing
    load_vtx(4, 1, 0, 0);     load_vtx(5, 0, 1, 0);
    load_vtx(6, 0, 0, 1);     load_vtx(7, 1, 1, 1);
    run_go(1'b0);
    // identical tetrahedra: intersecting
    load_vtx(4, 0, 0, 0);     load_vtx(5, 1, 0, 0);
    load_vtx(6, 0, 1, 0);     load_vtx(7, 0, 0, 1);
    run_go(1'b0);
    run_go(1'b1);
    // degenerate first simplex: all points equal, parallel edges
    load_vtx(0, 0, 0, 0);     load_vtx(1, 0, 0, 0);
    load_vtx(2, 0, 0, 0);     load_vtx(3, 0, 0, 0);
    run_go(1'b0);
    run_go(1'b1);
  endtask

  // random vertices, mostly in a small box so shapes overlap or touch
  task automatic test_random(int n_items);
    int span, base;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 4);
        base = $urandom_range(0, 255 - span);
        load_vtx($urandom_range(0, 7), base + $urandom_range(0, span),
                 base + $urandom_range(0, span), base + $urandom_range(0, span));
      end else begin
        run_go($urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    fail_count = 0;
    stall_mode = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    go_i = 1'b0;
    first_is_triangle_i = 1'b0;
    slot_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    coord_z_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1500);
    in_valid_i <= 1'b0;
    while (disjoint_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
